/* rtl/lpl_pkg.sv */
`default_nettype none
package lpl_pkg;

   localparam int unsigned DelayTapsDefault = 16;
   localparam logic [16:0] Unity = 17'h10000;

   localparam logic [15:0] ThresholdReset = 16'd32767;
   localparam logic [16:0] AttackReset    = 17'd65536;
   localparam logic [16:0] ReleaseReset   = 17'd655;

   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned CsrDataWidth  = 17;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_THRESHOLD = 2'd0,
      CSR_ATTACK    = 2'd1,
      CSR_RELEASE   = 2'd2,
      CSR_UNUSED    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [15:0] threshold;
      logic [16:0] attack_coeff;
      logic [16:0] release_coeff;
   } cfg_type;

   typedef struct packed {
      logic        start;
      logic [15:0] threshold;
      logic [31:0] peak;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [16:0] target;
   } div_rsp_type;

   function automatic logic [16:0] sat_coeff(input logic [16:0] v);
      return (v > Unity) ? Unity : v;
   endfunction

endpackage
`default_nettype wire

/* rtl/lpl_if.sv */
`default_nettype none
interface lpl_stream_if #(
   parameter int unsigned Width = 16
);
   logic             valid;
   logic             ready;
   logic [Width-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface lpl_csr_if;
   logic                                   valid;
   logic                                   ready;
   logic [lpl_pkg::CsrIndexWidth-1:0]      index;
   logic [lpl_pkg::CsrDataWidth-1:0]       data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* rtl/lpl_ram.sv */
`default_nettype none
module lpl_ram #(
   parameter int unsigned Width = 16,
   parameter int unsigned Depth = 16,
   localparam int unsigned AddrWidth = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [AddrWidth-1:0] wr_addr,
   input  wire logic [Width-1:0]     wr_data,
   input  wire logic [AddrWidth-1:0] rd_addr,
   output logic      [Width-1:0]     rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

/* rtl/lpl_div.sv */
`default_nettype none
module lpl_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lpl_pkg::div_req_type req,
   output lpl_pkg::div_rsp_type      rsp
);
   // quotient bits 17..0 are enough: results of 2^17 and above saturate,
   // flagged at start
   logic        busy_ff;
   logic        busy_in;
   logic [4:0]  count_ff;
   logic [4:0]  count_in;
   logic [48:0] rem_ff;
   logic [48:0] rem_in;
   logic [47:0] num_ff;
   logic [47:0] num_in;
   logic [31:0] den_ff;
   logic [31:0] den_in;
   logic [17:0] quo_ff;
   logic [17:0] quo_in;
   logic        ovf_ff;
   logic        ovf_in;
   logic        done_ff;
   logic        done_in;
   logic [48:0] trial;
   logic [48:0] shifted;

   // numerator threshold<<32 is 48 bits; quotient above 2^17 means saturate.
   // Overflow test: (threshold << 15) >= peak  <=> q >= 2^17.
   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      rem_in   = rem_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      quo_in   = quo_ff;
      ovf_in   = ovf_ff;
      done_in  = 1'b0;
      shifted  = {rem_ff[47:0], num_ff[47]};
      trial    = shifted - {17'd0, den_ff};
      if (req.start) begin
         busy_in  = (req.peak != 32'd0);
         done_in  = (req.peak == 32'd0);
         ovf_in   = ({16'd0, req.threshold, 15'd0} >= {15'd0, req.peak})
                    || (req.peak == 32'd0);
         // partial remainder starts at threshold<<14, below the divisor
         rem_in   = {1'b0, 18'd0, req.threshold, 14'd0};
         num_in   = 48'd0;
         den_in   = req.peak;
         quo_in   = 18'd0;
         count_in = 5'd18;
      end else if (busy_ff) begin
         num_in = {num_ff[46:0], 1'b0};
         if (!trial[48]) begin
            rem_in = trial;
            quo_in = {quo_ff[16:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[16:0], 1'b0};
         end
         count_in = count_ff - 5'd1;
         if (count_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      num_ff <= num_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      ovf_ff <= ovf_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.target = (ovf_ff || quo_ff > {1'b0, lpl_pkg::Unity}) ?
                       lpl_pkg::Unity : quo_ff[16:0];
endmodule
`default_nettype wire

/* rtl/lpl_core.sv */
`default_nettype none
module lpl_core #(
   parameter int unsigned DelayTaps = lpl_pkg::DelayTapsDefault,
   localparam int unsigned AddrWidth = (DelayTaps > 1) ? $clog2(DelayTaps) : 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire lpl_pkg::cfg_type cfg,
   lpl_stream_if.sink            req,
   lpl_stream_if.source          rsp
);
   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_PEAK, ST_DIV, ST_GAIN, ST_SCALE, ST_OUT
   } state_type;

   state_type            state_ff;
   logic [31:0]          peak_ff;
   logic [16:0]          gain_ff;
   logic signed [15:0]   sample_ff;
   logic [AddrWidth-1:0] pos_ff;
   logic [AddrWidth-1:0] pos_in;
   logic [31:0]          prod_ff;
   logic                 neg_ff;
   logic [15:0]          out_ff;
   logic                 rsp_valid_ff;

   logic [15:0]          ram_rd;
   logic                 ram_we;
   logic [AddrWidth-1:0] ram_wa;
   logic [15:0]          ram_wd;

   lpl_pkg::div_req_type div_req;
   lpl_pkg::div_rsp_type div_rsp;

   logic [15:0] mag;
   logic [31:0] mag_q;
   logic [16:0] pc;
   logic [48:0] peak_sum;
   logic [16:0] gc;
   logic [33:0] gain_sum;
   logic [16:0] gain_new;
   logic [15:0] dmag;
   logic [15:0] omag;

   assign pos_in = (pos_ff == AddrWidth'(DelayTaps - 1)) ? '0 : pos_ff + 1'b1;

   assign mag   = sample_ff[15] ? 16'(-sample_ff) : sample_ff;
   assign mag_q = {mag, 16'd0};
   assign pc    = (mag_q > peak_ff) ? cfg.attack_coeff : cfg.release_coeff;
   assign peak_sum = 49'(lpl_pkg::Unity - pc) * 49'(peak_ff) + 49'(pc) * 49'(mag_q);

   assign gc = (div_rsp.target < gain_ff) ? cfg.attack_coeff : cfg.release_coeff;
   assign gain_sum = 34'(lpl_pkg::Unity - gc) * 34'(gain_ff) + 34'(gc) * 34'(div_rsp.target);
   assign gain_new = (gain_sum[33:16] > 18'(lpl_pkg::Unity)) ? lpl_pkg::Unity :
                     gain_sum[32:16];

   assign dmag = ram_rd[15] ? 16'(-ram_rd) : ram_rd;
   assign omag = prod_ff[31:16];

   assign ram_we = (state_ff == ST_CLEAR) || (state_ff == ST_PEAK);
   assign ram_wa = pos_ff;
   assign ram_wd = (state_ff == ST_CLEAR) ? 16'd0 : sample_ff;

   lpl_ram #(.Width(16), .Depth(DelayTaps)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (pos_ff),
      .rd_data (ram_rd)
   );

   assign div_req.start     = (state_ff == ST_PEAK);
   assign div_req.threshold = cfg.threshold;
   assign div_req.peak      = peak_sum[47:16];

   lpl_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         pos_ff       <= '0;
         peak_ff      <= '0;
         gain_ff      <= lpl_pkg::Unity;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_CLEAR: begin
               pos_ff <= pos_in;
               if (pos_ff == AddrWidth'(DelayTaps - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req.valid) begin
                  sample_ff <= req.data;
                  state_ff  <= ST_PEAK;
               end
            end
            ST_PEAK: begin
               // ram read of the oldest word is issued in idle and is valid here
               peak_ff  <= peak_sum[47:16];
               neg_ff   <= ram_rd[15];
               prod_ff  <= {16'd0, dmag};
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (div_rsp.done) begin
                  gain_ff  <= gain_new;
                  state_ff <= ST_SCALE;
               end
            end
            ST_SCALE: begin
               prod_ff  <= prod_ff[15:0] * {15'd0, gain_ff};
               pos_ff   <= pos_in;
               state_ff <= ST_GAIN;
            end
            ST_GAIN: begin
               out_ff   <= neg_ff ? 16'(-omag) : omag;
               state_ff <= ST_OUT;
               rsp_valid_ff <= 1'b1;
            end
            ST_OUT: begin
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = out_ff;

   always_ff @(posedge clock) begin
      if (!reset) begin
         assert (!(rsp_valid_ff && req.ready))
            else $error("input taken while a word is pending");
         assert (gain_ff <= lpl_pkg::Unity)
            else $error("gain above unity");
      end
   end

   a_start_only_from_peak: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> $past(state_ff) == ST_IDLE)
      else $error("divider started outside peak step");
   a_out_after_gain: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_GAIN)
      else $error("result raised outside gain step");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |=> rsp_valid_ff && $stable(out_ff))
      else $error("pending word dropped");
endmodule
`default_nettype wire

/* rtl/lookahead_peak_limiter.sv */
`default_nettype none
// channel  | direction | payload
// req      | in        | sample_in, 16 bit signed
// rsp      | out       | sample_out, 16 bit signed
// csr      | in        | index 2 bit, data 17 bit
//
// Input words are taken one at a time.
// The result is offered once its word has passed the peak, divide, scale and gain steps.
// Most of that time goes to the 18-step divider.
// After reset the delay memory is cleared one entry a cycle;
// no word is taken meanwhile, register writes are.
// A stalled result holds until taken; the next word waits for it.
module lookahead_peak_limiter #(
   parameter int unsigned DelayTaps = lpl_pkg::DelayTapsDefault
) (
   input wire logic     clock,
   input wire logic     reset,
   lpl_stream_if.sink   req,
   lpl_stream_if.source rsp,
   lpl_csr_if.sink      csr
);
   lpl_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold     <= lpl_pkg::ThresholdReset;
         cfg_ff.attack_coeff  <= lpl_pkg::AttackReset;
         cfg_ff.release_coeff <= lpl_pkg::ReleaseReset;
      end else if (csr.valid) begin
         unique case (lpl_pkg::csr_index_type'(csr.index))
            lpl_pkg::CSR_THRESHOLD: cfg_ff.threshold <= csr.data[15:0];
            lpl_pkg::CSR_ATTACK:    cfg_ff.attack_coeff <= lpl_pkg::sat_coeff(csr.data);
            lpl_pkg::CSR_RELEASE:   cfg_ff.release_coeff <= lpl_pkg::sat_coeff(csr.data);
            default: ;
         endcase
      end
   end

   assign csr.ready = 1'b1;

   lpl_core #(.DelayTaps(DelayTaps)) u_core (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .req   (req),
      .rsp   (rsp)
   );
endmodule
`default_nettype wire

/* tb/lpl_tb_pkg.sv */
`default_nettype none
package lpl_tb_pkg;

   class limiter_scoreboard;
      logic [15:0] threshold;
      logic [16:0] attack;
      logic [16:0] release_c;
      logic [31:0] peak;
      logic [16:0] gain;
      logic signed [15:0] taps [16];
      int unsigned pos;
      logic signed [15:0] pending_out [$];
      int errors;
      int checked;

      function new();
         threshold = lpl_pkg::ThresholdReset;
         attack = lpl_pkg::AttackReset;
         release_c = lpl_pkg::ReleaseReset;
         peak = 0;
         gain = lpl_pkg::Unity;
         foreach (taps[i]) taps[i] = 0;
         pos = 0;
         errors = 0;
         checked = 0;
      endfunction

      function void write_reg(lpl_pkg::csr_index_type idx, logic [16:0] v);
         logic [16:0] s;
         s = (v > lpl_pkg::Unity) ? lpl_pkg::Unity : v;
         case (idx)
            lpl_pkg::CSR_THRESHOLD: threshold = v[15:0];
            lpl_pkg::CSR_ATTACK: attack = s;
            lpl_pkg::CSR_RELEASE: release_c = s;
            default: ;
         endcase
      endfunction

      static function logic [63:0] smooth(logic [63:0] old, logic [63:0] x,
                                          logic [16:0] c);
         return ((64'(lpl_pkg::Unity) - c) * old + 64'(c) * x) >> 16;
      endfunction

      function void note_word(logic signed [15:0] s);
         logic [31:0] mag_q;
         logic [16:0] c;
         logic [16:0] target;
         logic [63:0] q;
         logic signed [15:0] d;
         logic [31:0] dmag;
         logic [31:0] omag;
         logic [63:0] g;
         mag_q = (s < 0) ? 32'(-32'(s)) << 16 : 32'(s) << 16;
         c = (mag_q > peak) ? attack : release_c;
         peak = 32'(smooth(peak, mag_q, c));
         if (peak == 0) begin
            target = lpl_pkg::Unity;
         end else begin
            q = {16'd0, threshold, 32'd0} / 64'(peak);
            target = (q > lpl_pkg::Unity) ? lpl_pkg::Unity : 17'(q);
         end
         c = (target < gain) ? attack : release_c;
         g = smooth(gain, target, c);
         gain = (g > lpl_pkg::Unity) ? lpl_pkg::Unity : 17'(g);
         d = taps[pos];
         taps[pos] = s;
         pos = (pos + 1) % 16;
         dmag = (d < 0) ? 32'(-32'(d)) : 32'(d);
         omag = 32'((64'(dmag) * gain) >> 16);
         pending_out.push_back((d < 0) ? -16'(omag) : 16'(omag));
      endfunction

      function void check_word(logic signed [15:0] got);
         logic signed [15:0] exp_v;
         if (pending_out.size() == 0) begin
            $error("sample_out: unexpected word, actual %0d", got);
            errors++;
            return;
         end
         exp_v = pending_out.pop_front();
         checked++;
         if (got !== exp_v) begin
            $error("sample_out: expected %0d, actual %0d", exp_v, got);
            errors++;
         end
      endfunction
   endclass
endpackage
`default_nettype wire

/* tb/tb_lookahead_peak_limiter.sv */
`default_nettype none
module tb_lookahead_peak_limiter;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock;
   logic reset;
   lpl_stream_if #(.Width(16)) req ();
   lpl_stream_if #(.Width(16)) rsp ();
   lpl_csr_if csr ();
   lpl_tb_pkg::limiter_scoreboard sb;
   int n_words;
   int n_cfg;

   lookahead_peak_limiter dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source), .csr(csr.sink)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("TEST FAILED");
      $finish;
   end

   // receiver stall pattern
   initial begin
      int mode;
      rsp.ready = 0;
      forever begin
         @(posedge clock);
         mode = (n_words / 150) % 3;
         if (mode == 0) rsp.ready <= 1;
         else if (mode == 1) rsp.ready <= ($urandom_range(0, 3) != 0);
         else rsp.ready <= ($urandom_range(0, 9) < 3);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) sb.check_word($signed(rsp.data));
   end

   task automatic send_word(logic [15:0] s);
      req.valid <= 1;
      req.data <= s;
      do @(posedge clock); while (!req.ready);
      sb.note_word($signed(s));
      n_words++;
   endtask

   task automatic pause(int n);
      req.valid <= 0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain();
      int guard;
      req.valid <= 0;
      guard = 0;
      while (sb.pending_out.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(lpl_pkg::csr_index_type idx, logic [16:0] v);
      csr.valid <= 1;
      csr.index <= idx;
      csr.data <= v;
      do @(posedge clock); while (!csr.ready);
      sb.write_reg(idx, v);
      n_cfg++;
      csr.valid <= 0;
   endtask

   function automatic logic [15:0] rand_sample();
      case ($urandom_range(0, 5))
         0: return 16'(16'sh8000 + $urandom_range(0, 3));
         1: return 16'(16'sh7fff - $urandom_range(0, 3));
         2: return 16'($urandom_range(0, 64) - 32);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_words(int n);
      int left;
      int burst;
      left = n;
      while (left > 0) begin
         burst = $urandom_range(1, 20);
         for (int i = 0; i < burst && left > 0; i++) begin
            send_word(rand_sample());
            left--;
         end
         if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 40));
      end
      drain();
   endtask

   initial begin
      logic [16:0] setting [6][3];
      sb = new();
      n_words = 0;
      n_cfg = 0;
      reset = 1;
      req.valid = 0;
      req.data = 0;
      csr.valid = 0;
      csr.index = lpl_pkg::CSR_THRESHOLD;
      csr.data = 0;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes under reset settings, then saturating and unused register writes
      send_word(16'sh7fff);
      send_word(16'sh8000);
      send_word(16'h0000);
      send_word(16'hffff);
      send_word(16'h0001);
      for (int i = 0; i < 14; i++) send_word(i[0] ? 16'h8000 : 16'h7fff);
      drain();
      write_reg(lpl_pkg::CSR_UNUSED, 17'h1ffff);
      write_reg(lpl_pkg::CSR_THRESHOLD, 17'd0);
      write_reg(lpl_pkg::CSR_ATTACK, 17'h1ffff);
      write_reg(lpl_pkg::CSR_RELEASE, 17'h10001);
      for (int i = 0; i < 6; i++) send_word(16'h8000);
      drain();

      setting[0] = '{17'd0, 17'd0, 17'd0};
      setting[1] = '{17'd65535, 17'd65536, 17'd65536};
      setting[2] = '{17'd1000, 17'd30000, 17'd100};
      setting[3] = '{17'd16384, 17'd1, 17'd1};
      setting[4] = '{17'd32767, 17'd65536, 17'd655};
      setting[5] = '{17'd8000, 17'd20000, 17'd65535};
      for (int p = 0; p < 7; p++) begin
         if (p < 6) begin
            write_reg(lpl_pkg::CSR_THRESHOLD, setting[p][0]);
            write_reg(lpl_pkg::CSR_ATTACK, setting[p][1]);
            write_reg(lpl_pkg::CSR_RELEASE, setting[p][2]);
         end else begin
            write_reg(lpl_pkg::CSR_THRESHOLD, 17'($urandom));
            write_reg(lpl_pkg::CSR_ATTACK, 17'($urandom_range(0, 131071)));
            write_reg(lpl_pkg::CSR_RELEASE, 17'($urandom_range(0, 131071)));
         end
         random_words(150);
      end

      drain();
      $display("Covered %0d words, %0d register writes, %0d results checked.",
               n_words, n_cfg, sb.checked);
      $display("Settings swept from zero threshold and coefficients to full scale.");
      if (sb.errors == 0 && sb.pending_out.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire

/* files.f */
rtl/lpl_pkg.sv
rtl/lpl_if.sv
rtl/lpl_ram.sv
rtl/lpl_div.sv
rtl/lpl_core.sv
rtl/lookahead_peak_limiter.sv
tb/lpl_tb_pkg.sv
tb/tb_lookahead_peak_limiter.sv
